// ----- hw/rtl/rotation_matrix_to_quaternion_unit_assert.svh -----
// Assertion macros shared by the rotation-matrix-to-quaternion RTL.
// Included by the modules that check their own pipeline invariants.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RMQ_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rmq check failed");

// Next-cycle implication, disabled in reset.
`define RMQ_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rmq check failed");

`endif

// ----- hw/rtl/rmq_pkg.sv -----
// Shared constants and types for the rotation-matrix-to-quaternion unit.
// No dependencies.
`default_nettype none

package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int NUM_LANES  = 3;

  typedef enum logic [1:0] {
    CASE_W = 2'd0,
    CASE_X = 2'd1,
    CASE_Y = 2'd2,
    CASE_Z = 2'd3
  } lead_case_t;

  // control that travels with each item through the stages
  typedef struct packed {
    logic       vld;
    lead_case_t lc;
  } rmq_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rmq_if.sv -----
// Valid/ready channel interfaces: matrix in, quaternion out.
// Depends on rmq_pkg for default widths.
`default_nettype none

interface rmq_mat_if #(parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a00, a01, a02;
  logic signed [DATA_WIDTH-1:0] a10, a11, a12;
  logic signed [DATA_WIDTH-1:0] a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

interface rmq_quat_if #(parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_x, quat_y, quat_z, quat_w;
  logic [1:0]                   leading_case;
  logic                         saturated;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, leading_case, saturated,
                  input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, leading_case, saturated,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rotation_matrix_to_quaternion_unit.sv -----
// Top level: rotation matrix (Q2.14 by default) to quaternion, four-case trace method.
// Depends on rmq_pkg, rmq_if, rmq_front, rmq_sqrt, rmq_div and the assertion header.
//
// Usage:
//   mat  (sink)   : nine matrix entries a00..a22, valid/ready; an item is taken
//                   at a clock edge with valid and ready both high.
//   quat (source) : quat_x/y/z/w, leading_case, saturated, valid/ready.
// Throughput: one matrix per cycle while the output is not stalled (see Stall).
// Pipeline: front register, RTW = ceil((DATA_WIDTH+2+FRAC_BITS)/2) square-root
//   stages, DDW = DATA_WIDTH+1+FRAC_BITS divider stages, then the output
//   register. The square root and the divider chain make one bit per stage each.
// Reset (rst, synchronous): clears every stage valid bit; no item is in flight
//   after it and quat.valid is low.
// Stall: the whole pipeline advances on one enable, high when the output
//   register is empty or being taken. While quat holds a result that is not
//   taken, mat.ready is low and every stage holds; nothing is lost or repeated.
`default_nettype none
`include "rotation_matrix_to_quaternion_unit_assert.svh"

module rotation_matrix_to_quaternion_unit #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS
) (
  input wire logic  clk,
  input wire logic  rst,
  rmq_mat_if.sink   mat,
  rmq_quat_if.source quat
);

  localparam int DW   = DATA_WIDTH;
  localparam int NW   = DW + 1;                 // numerator: sum or difference of two entries
  localparam int RADW = DW + 2;                 // clamped radicand
  localparam int RTW  = (RADW + FRAC_BITS + 1) / 2;
  localparam int DDW  = NW + FRAC_BITS;         // dividend |num| << FRAC_BITS
  localparam int CW   = (RTW > DW) ? RTW : DW;
  localparam int L    = rmq_pkg::NUM_LANES;

  localparam logic signed [DW-1:0] QMAX    = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] QMIN    = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DDW-1:0]       QMAX_Q  = {{(DDW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [DDW-1:0]       QMAX1_Q = {{(DDW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};
  localparam logic [CW-1:0]        QMAX_C  = CW'({(DW-1){1'b1}});

  logic en;

  rmq_pkg::rmq_ctl_t    f_ctl, s_ctl, d_ctl;
  logic [RADW-1:0]      f_rad;
  logic signed [NW-1:0] f_n [L];
  logic signed [NW-1:0] s_n [L];
  logic [RTW-1:0]       s_root, d_root;
  logic [DDW-1:0]       d_q   [L];
  logic                 d_neg [L];
  logic                 d_zr  [L];

  logic signed [DW-1:0] term [L];
  logic [CW-1:0]        lead_c;
  logic signed [DW-1:0] lead;
  logic                 sat_next;
  logic signed [DW-1:0] x_next, y_next, z_next, w_next;

  logic                 out_vld;
  logic signed [DW-1:0] qx, qy, qz, qw;
  logic [1:0]           lc_out;
  logic                 sat_out;

  // single pipeline enable
  assign en        = !out_vld || quat.ready;
  assign mat.ready = en;

  rmq_front #(.DW(DW), .FB(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (mat.valid),
    .a00    (mat.a00), .a01 (mat.a01), .a02 (mat.a02),
    .a10    (mat.a10), .a11 (mat.a11), .a12 (mat.a12),
    .a20    (mat.a20), .a21 (mat.a21), .a22 (mat.a22),
    .ctl    (f_ctl),
    .rad    (f_rad),
    .n      (f_n)
  );

  rmq_sqrt #(.RADW(RADW), .FB(FRAC_BITS), .NW(NW), .RTW(RTW)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (f_ctl),
    .rad     (f_rad),
    .n_in    (f_n),
    .ctl_out (s_ctl),
    .root    (s_root),
    .n_out   (s_n)
  );

  rmq_div #(.NW(NW), .FB(FRAC_BITS), .RTW(RTW), .DDW(DDW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (s_ctl),
    .root_in  (s_root),
    .n_in     (s_n),
    .ctl_out  (d_ctl),
    .root_out (d_root),
    .q        (d_q),
    .neg      (d_neg),
    .zr       (d_zr)
  );

  // saturation of leading term and quotients, then place terms by case
  assign lead_c = CW'(d_root >> 1);

  always_comb begin
    sat_next = 1'b0;
    if (lead_c > QMAX_C) begin
      sat_next = 1'b1;
      lead     = QMAX;
    end else begin
      lead = lead_c[DW-1:0];
    end

    for (int j = 0; j < L; j++) begin
      if (d_root == '0) begin
        // zero divisor: sign of the numerator picks the limit; a zero numerator gives zero
        sat_next = 1'b1;
        term[j]  = d_zr[j] ? '0 : (d_neg[j] ? QMIN : QMAX);
      end else if (d_neg[j]) begin
        if (d_q[j] > QMAX1_Q) begin
          sat_next = 1'b1;
          term[j]  = QMIN;
        end else begin
          term[j] = -d_q[j][DW-1:0];
        end
      end else begin
        if (d_q[j] > QMAX_Q) begin
          sat_next = 1'b1;
          term[j]  = QMAX;
        end else begin
          term[j] = d_q[j][DW-1:0];
        end
      end
    end

    case (d_ctl.lc)
      rmq_pkg::CASE_W: begin
        w_next = lead;    x_next = term[0]; y_next = term[1]; z_next = term[2];
      end
      rmq_pkg::CASE_X: begin
        w_next = term[0]; x_next = lead;    y_next = term[1]; z_next = term[2];
      end
      rmq_pkg::CASE_Y: begin
        w_next = term[0]; x_next = term[1]; y_next = lead;    z_next = term[2];
      end
      default: begin
        w_next = term[0]; x_next = term[1]; y_next = term[2]; z_next = lead;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= d_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx      <= x_next;
      qy      <= y_next;
      qz      <= z_next;
      qw      <= w_next;
      lc_out  <= d_ctl.lc;
      sat_out <= sat_next;
    end
  end

  assign quat.valid        = out_vld;
  assign quat.quat_x       = qx;
  assign quat.quat_y       = qy;
  assign quat.quat_z       = qz;
  assign quat.quat_w       = qw;
  assign quat.leading_case = lc_out;
  assign quat.saturated    = sat_out;

  // the leading term is a halved root: never negative
  `RMQ_ASSERT_IMP(a_lead_w_pos, clk, rst, quat.valid && (quat.leading_case == rmq_pkg::CASE_W), !quat.quat_w[DW-1])
  `RMQ_ASSERT_IMP(a_lead_x_pos, clk, rst, quat.valid && (quat.leading_case == rmq_pkg::CASE_X), !quat.quat_x[DW-1])
  // a held result freezes the whole pipeline, input included
  `RMQ_ASSERT_IMP(a_stall_in, clk, rst, quat.valid && !quat.ready, !mat.ready)
  // a stalled result is still there next cycle
  `RMQ_ASSERT_NXT(a_stall_hold, clk, rst, quat.valid && !quat.ready, quat.valid)

endmodule

`default_nettype wire

// ----- hw/rtl/rmq_front.sv -----
// Front stage: trace, case select, clamped radicand and the three numerators.
// Depends on rmq_pkg.
`default_nettype none

module rmq_front #(
  parameter int DW = rmq_pkg::DATA_WIDTH,
  parameter int FB = rmq_pkg::FRAC_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic signed [DW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
  output rmq_pkg::rmq_ctl_t        ctl,
  output logic        [DW+1:0]     rad,
  output logic signed [DW:0]       n [rmq_pkg::NUM_LANES]
);

  localparam int EW = DW + 3;
  localparam int NW = DW + 1;
  localparam logic signed [EW-1:0] ONE_E = EW'(1) <<< FB;

  logic signed [EW-1:0] e00, e11, e22, tr, rad_w, rad_x, rad_y, rad_z, rad_sel;
  logic signed [NW-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  logic signed [NW-1:0] n_next [rmq_pkg::NUM_LANES];
  rmq_pkg::lead_case_t  lc_next;

  assign e00 = EW'(a00);
  assign e11 = EW'(a11);
  assign e22 = EW'(a22);
  assign tr  = e00 + e11 + e22;

  assign rad_w = ONE_E + tr;
  assign rad_x = ONE_E + e00 - e11 - e22;
  assign rad_y = ONE_E + e11 - e00 - e22;
  assign rad_z = ONE_E + e22 - e00 - e11;

  assign d21_12 = NW'(a21) - NW'(a12);
  assign d02_20 = NW'(a02) - NW'(a20);
  assign d10_01 = NW'(a10) - NW'(a01);
  assign s01_10 = NW'(a01) + NW'(a10);
  assign s02_20 = NW'(a02) + NW'(a20);
  assign s12_21 = NW'(a12) + NW'(a21);

  // ties fall to the later case
  always_comb begin
    if (tr > 0)                    lc_next = rmq_pkg::CASE_W;
    else if (a00 > a11 && a00 > a22) lc_next = rmq_pkg::CASE_X;
    else if (a11 > a22)            lc_next = rmq_pkg::CASE_Y;
    else                           lc_next = rmq_pkg::CASE_Z;
  end

  // lanes hold the non-leading terms in w, x, y, z order
  always_comb begin
    case (lc_next)
      rmq_pkg::CASE_W: begin
        rad_sel = rad_w;
        n_next[0] = d21_12; n_next[1] = d02_20; n_next[2] = d10_01;
      end
      rmq_pkg::CASE_X: begin
        rad_sel = rad_x;
        n_next[0] = d21_12; n_next[1] = s01_10; n_next[2] = s02_20;
      end
      rmq_pkg::CASE_Y: begin
        rad_sel = rad_y;
        n_next[0] = d02_20; n_next[1] = s01_10; n_next[2] = s12_21;
      end
      default: begin
        rad_sel = rad_z;
        n_next[0] = d10_01; n_next[1] = s02_20; n_next[2] = s12_21;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else if (en) begin
      ctl.vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.lc <= lc_next;
      rad    <= rad_sel[EW-1] ? '0 : rad_sel[DW+1:0];
      n      <= n_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rmq_sqrt.sv -----
// Pipelined restoring square root, one root bit per stage.
// Depends on rmq_pkg and the assertion macro header.
`default_nettype none
`include "rotation_matrix_to_quaternion_unit_assert.svh"

module rmq_sqrt #(
  parameter int RADW = rmq_pkg::DATA_WIDTH + 2,
  parameter int FB   = rmq_pkg::FRAC_BITS,
  parameter int NW   = rmq_pkg::DATA_WIDTH + 1,
  parameter int RTW  = (RADW + FB + 1) / 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire rmq_pkg::rmq_ctl_t    ctl_in,
  input  wire logic        [RADW-1:0] rad,
  input  wire logic signed [NW-1:0] n_in [rmq_pkg::NUM_LANES],
  output rmq_pkg::rmq_ctl_t         ctl_out,
  output logic             [RTW-1:0] root,
  output logic signed      [NW-1:0] n_out [rmq_pkg::NUM_LANES]
);

  localparam int SQW = 2 * RTW;

  rmq_pkg::rmq_ctl_t    ctl_s  [RTW+1];
  logic [RTW+1:0]       rem_s  [RTW+1];
  logic [RTW-1:0]       root_s [RTW+1];
  logic [SQW-1:0]       v_s    [RTW+1];
  logic signed [NW-1:0] n_s    [RTW+1][rmq_pkg::NUM_LANES];
  logic [RTW+1:0]       bound;

  // radicand scaled by 2^FB
  assign ctl_s[0]  = ctl_in;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign v_s[0]    = SQW'({rad, {FB{1'b0}}});
  assign n_s[0]    = n_in;

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [RTW+1:0] cat, trial;
    logic           take;

    assign cat   = {rem_s[k][RTW-1:0], v_s[k][SQW-1 -: 2]};
    assign trial = {root_s[k], 2'b01};
    assign take  = (cat >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[k+1].vld <= 1'b0;
      end else if (en) begin
        ctl_s[k+1].vld <= ctl_s[k].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_s[k+1].lc <= ctl_s[k].lc;
        rem_s[k+1]    <= take ? (cat - trial) : cat;
        root_s[k+1]   <= {root_s[k][RTW-2:0], take};
        v_s[k+1]      <= {v_s[k][SQW-3:0], 2'b00};
        n_s[k+1]      <= n_s[k];
      end
    end
  end

  assign ctl_out = ctl_s[RTW];
  assign root    = root_s[RTW];
  assign n_out   = n_s[RTW];

  // final remainder never exceeds 2*root
  assign bound = {1'b0, root_s[RTW], 1'b0};
  `RMQ_ASSERT_IMP(a_sqrt_rem, clk, rst, ctl_s[RTW].vld, rem_s[RTW] <= bound)

endmodule

`default_nettype wire

// ----- hw/rtl/rmq_div.sv -----
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Divisor is 2*root, dividend is |numerator| << FB. Depends on rmq_pkg and the assertion header.
`default_nettype none
`include "rotation_matrix_to_quaternion_unit_assert.svh"

module rmq_div #(
  parameter int NW  = rmq_pkg::DATA_WIDTH + 1,
  parameter int FB  = rmq_pkg::FRAC_BITS,
  parameter int RTW = 16,
  parameter int DDW = NW + FB
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire rmq_pkg::rmq_ctl_t    ctl_in,
  input  wire logic       [RTW-1:0] root_in,
  input  wire logic signed [NW-1:0] n_in [rmq_pkg::NUM_LANES],
  output rmq_pkg::rmq_ctl_t         ctl_out,
  output logic            [RTW-1:0] root_out,
  output logic            [DDW-1:0] q    [rmq_pkg::NUM_LANES],
  output logic                      neg  [rmq_pkg::NUM_LANES],
  output logic                      zr   [rmq_pkg::NUM_LANES]
);

  localparam int DVW = RTW + 1;
  localparam int L   = rmq_pkg::NUM_LANES;

  rmq_pkg::rmq_ctl_t ctl_s  [DDW+1];
  logic [RTW-1:0]    root_s [DDW+1];
  logic [DVW:0]      rem_s  [DDW+1][L];
  logic [DDW-1:0]    dq_s   [DDW+1][L];
  logic              neg_s  [DDW+1][L];
  logic              zr_s   [DDW+1][L];
  logic [DVW:0]      dv_o;
  logic              rem_ok;

  assign ctl_s[0]  = ctl_in;
  assign root_s[0] = root_in;

  for (genvar j = 0; j < L; j++) begin : g_in
    logic [NW-1:0] mag;
    assign mag         = n_in[j][NW-1] ? NW'(-n_in[j]) : NW'(n_in[j]);
    assign rem_s[0][j] = '0;
    assign dq_s[0][j]  = {mag, {FB{1'b0}}};
    assign neg_s[0][j] = n_in[j][NW-1];
    assign zr_s[0][j]  = (n_in[j] == '0);
  end

  for (genvar k = 0; k < DDW; k++) begin : g_stage
    logic [DVW:0] dv;
    assign dv = {1'b0, root_s[k], 1'b0};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[k+1].vld <= 1'b0;
      end else if (en) begin
        ctl_s[k+1].vld <= ctl_s[k].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_s[k+1].lc <= ctl_s[k].lc;
        root_s[k+1]   <= root_s[k];
      end
    end

    for (genvar j = 0; j < L; j++) begin : g_lane
      logic [DVW:0] t;
      logic         take;

      assign t    = {rem_s[k][j][DVW-1:0], dq_s[k][j][DDW-1]};
      assign take = (t >= dv);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[k+1][j] <= take ? (t - dv) : t;
          dq_s[k+1][j]  <= {dq_s[k][j][DDW-2:0], take};
          neg_s[k+1][j] <= neg_s[k][j];
          zr_s[k+1][j]  <= zr_s[k][j];
        end
      end
    end
  end

  assign ctl_out  = ctl_s[DDW];
  assign root_out = root_s[DDW];
  assign q        = dq_s[DDW];
  assign neg      = neg_s[DDW];
  assign zr       = zr_s[DDW];

  // with a nonzero divisor every lane ends with remainder below it
  assign dv_o   = {1'b0, root_s[DDW], 1'b0};
  assign rem_ok = (rem_s[DDW][0] < dv_o) && (rem_s[DDW][1] < dv_o) && (rem_s[DDW][2] < dv_o);
  `RMQ_ASSERT_IMP(a_div_rem, clk, rst, ctl_s[DDW].vld && (root_s[DDW] != '0), rem_ok)

endmodule

`default_nettype wire
